FILE: rtl/lsbc_pkg.sv
// ----------------------------------------------------------------------------
// lsbc_pkg
// Shared types and constants for the LED light-state blink controller.
// ----------------------------------------------------------------------------
package lsbc_pkg;

   localparam logic [2:0] ID_LCD       = 3'd0;
   localparam logic [2:0] ID_BUTTONS   = 3'd1;
   localparam logic [2:0] ID_ATTENTION = 3'd2;
   localparam logic [2:0] ID_NOTIFY    = 3'd3;

   localparam logic [1:0] TGT_LCD     = 2'd0;
   localparam logic [1:0] TGT_BUTTONS = 2'd1;
   localparam logic [1:0] TGT_WHITE   = 2'd2;
   localparam logic [1:0] TGT_NONE    = 2'd3;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_UNSUP = 1'b1;

   localparam logic [1:0] FLASH_TIMED = 2'd1;

   localparam logic [15:0] LUMA_R = 16'd77;
   localparam logic [15:0] LUMA_G = 16'd150;
   localparam logic [15:0] LUMA_B = 16'd29;

   localparam int          FREQ_DIV = 50;
   localparam logic [11:0] FREQ_MAX = 12'd4095;
   localparam logic [7:0]  PWM_MIN  = 8'd16;

   // per-request control carried from front to back
   typedef struct packed {
      logic       status;
      logic [1:0] target;
      logic [7:0] brightness;
      logic       blink;
   } cmd_ctrl_type;

   typedef enum logic {
      ST_IDLE,
      ST_DIV
   } back_state_type;

endpackage

FILE: rtl/lsbc_front.sv
// ----------------------------------------------------------------------------
// lsbc_front
// Accepts requests, updates the white LED slots, picks the shown slot and
// computes luma brightness; pushes one command per request into the queue.
// ----------------------------------------------------------------------------
module lsbc_front #(
   parameter int TIME_WIDTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [2:0]                req_light_id,
   input  logic [23:0]               req_color,
   input  logic [1:0]                req_flash_mode,
   input  logic [15:0]               req_on_ms,
   input  logic [15:0]               req_off_ms,
   input  logic                      q_full,
   output logic                      push,
   output lsbc_pkg::cmd_ctrl_type    push_ctrl,
   output logic [TIME_WIDTH-1:0]     push_on,
   output logic [TIME_WIDTH-1:0]     push_off
);

   localparam logic [31:0] TIME_MAX = 32'((64'd1 << TIME_WIDTH) - 64'd1);

   logic [23:0]           color_ff [2];
   logic [1:0]            mode_ff  [2];
   logic [TIME_WIDTH-1:0] on_ff    [2];
   logic [TIME_WIDTH-1:0] off_ff   [2];
   logic [23:0]           color_in [2];
   logic [1:0]            mode_in  [2];
   logic [TIME_WIDTH-1:0] on_in    [2];
   logic [TIME_WIDTH-1:0] off_in   [2];

   logic [31:0]           on_wide, off_wide;
   logic [TIME_WIDTH-1:0] on_sat, off_sat;
   logic                  is_white, slot_sel, use_sel, timed;
   logic [23:0]           luma_color;
   logic [15:0]           luma_sum;

   assign req_ready = !q_full;
   assign push      = req_valid && !q_full;

   assign on_wide  = {16'd0, req_on_ms};
   assign off_wide = {16'd0, req_off_ms};
   assign on_sat   = (on_wide  > TIME_MAX) ? TIME_MAX[TIME_WIDTH-1:0] : on_wide[TIME_WIDTH-1:0];
   assign off_sat  = (off_wide > TIME_MAX) ? TIME_MAX[TIME_WIDTH-1:0] : off_wide[TIME_WIDTH-1:0];

   assign is_white = (req_light_id == lsbc_pkg::ID_ATTENTION) ||
                     (req_light_id == lsbc_pkg::ID_NOTIFY);
   assign slot_sel = (req_light_id == lsbc_pkg::ID_NOTIFY);

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         color_in[i] = color_ff[i];
         mode_in[i]  = mode_ff[i];
         on_in[i]    = on_ff[i];
         off_in[i]   = off_ff[i];
         if (push && is_white && (slot_sel == 1'(i))) begin
            color_in[i] = req_color;
            mode_in[i]  = req_flash_mode;
            on_in[i]    = on_sat;
            off_in[i]   = off_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 2; i++) begin
            color_ff[i] <= '0;
            mode_ff[i]  <= '0;
            on_ff[i]    <= '0;
            off_ff[i]   <= '0;
         end
      end else begin
         for (int i = 0; i < 2; i++) begin
            color_ff[i] <= color_in[i];
            mode_ff[i]  <= mode_in[i];
            on_ff[i]    <= on_in[i];
            off_ff[i]   <= off_in[i];
         end
      end
   end

   // slot 1 shows only when slot 0 is black and slot 1 is not
   assign use_sel = (color_in[0] == 24'd0) && (color_in[1] != 24'd0);
   assign timed   = (mode_in[use_sel] == lsbc_pkg::FLASH_TIMED);

   assign luma_color = is_white ? color_in[use_sel] : req_color;
   assign luma_sum   = lsbc_pkg::LUMA_R * {8'd0, luma_color[23:16]} +
                       lsbc_pkg::LUMA_G * {8'd0, luma_color[15:8]} +
                       lsbc_pkg::LUMA_B * {8'd0, luma_color[7:0]};

   always_comb begin
      push_ctrl.status     = lsbc_pkg::STATUS_OK;
      push_ctrl.target     = lsbc_pkg::TGT_NONE;
      push_ctrl.brightness = luma_sum[15:8];
      push_ctrl.blink      = 1'b0;
      push_on              = on_in[use_sel];
      push_off             = off_in[use_sel];
      unique case (req_light_id) inside
         lsbc_pkg::ID_LCD: begin
            push_ctrl.target = lsbc_pkg::TGT_LCD;
         end
         lsbc_pkg::ID_BUTTONS: begin
            push_ctrl.target = lsbc_pkg::TGT_BUTTONS;
         end
         lsbc_pkg::ID_ATTENTION, lsbc_pkg::ID_NOTIFY: begin
            push_ctrl.target = lsbc_pkg::TGT_WHITE;
            push_ctrl.blink  = timed && (on_in[use_sel] != '0) && (off_in[use_sel] != '0);
         end
         default: begin
            push_ctrl.status     = lsbc_pkg::STATUS_UNSUP;
            push_ctrl.brightness = 8'd0;
         end
      endcase
   end

endmodule

FILE: rtl/lsbc_queue.sv
// ----------------------------------------------------------------------------
// lsbc_queue
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
module lsbc_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             q_valid,
   output logic [WIDTH-1:0] q_data
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic             wr_ptr_in, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign full    = (count_ff == 2'd2);
   assign q_valid = (count_ff != 2'd0);
   assign q_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/lsbc_div.sv
// ----------------------------------------------------------------------------
// lsbc_div
// Iterative restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lsbc_div #(
   parameter int DW = 24,
   parameter int VW = 17
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          busy,
   output logic [DW-1:0] quotient
);

   localparam int CW = $clog2(DW + 1);

   logic          busy_ff, busy_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [VW-1:0] dvs_ff, dvs_in;
   logic [VW:0]   shifted, diff;

   assign shifted  = {rem_ff, quo_ff[DW-1]};
   assign diff     = shifted - {1'b0, dvs_ff};
   assign busy     = busy_ff;
   assign quotient = quo_ff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DW);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         cnt_in  = cnt_ff - CW'(1);
         busy_in = (cnt_ff != CW'(1));
         if (!diff[VW]) begin
            rem_in = diff[VW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = shifted[VW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

endmodule

FILE: rtl/lsbc_back.sv
// ----------------------------------------------------------------------------
// lsbc_back
// Takes commands from the queue, runs the pwm divider, scales the group
// frequency and holds the response register.
// ----------------------------------------------------------------------------
module lsbc_back #(
   parameter int TIME_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  lsbc_pkg::cmd_ctrl_type q_ctrl,
   input  logic [TIME_WIDTH-1:0]  q_on,
   input  logic [TIME_WIDTH-1:0]  q_off,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_status,
   output logic [1:0]             rsp_target,
   output logic [7:0]             rsp_brightness,
   output logic                   rsp_blink,
   output logic [11:0]            rsp_group_freq,
   output logic [7:0]             rsp_group_pwm
);

   localparam int VW = TIME_WIDTH + 1;
   localparam int DW = TIME_WIDTH + 8;
   localparam int FS = VW + 6;
   // ceil(2^FS / 50): exact total / 50 for every total below 2^VW
   localparam logic [63:0] FREQ_RECIP =
      ((64'd1 << FS) + 64'(lsbc_pkg::FREQ_DIV) - 64'd1) / 64'(lsbc_pkg::FREQ_DIV);

   lsbc_pkg::back_state_type state_ff, state_in;
   lsbc_pkg::cmd_ctrl_type   cur_ff, cur_in, out_ff, out_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [11:0]              freq_ff, freq_in;
   logic [7:0]               pwm_ff, pwm_in;
   logic [VW-1:0]            tot_ff, tot_in;

   logic          out_free, div_start, pwm_busy;
   logic [VW-1:0] total;
   logic [2*VW:0] freq_prod;
   logic [DW-1:0] pwm_dividend, freq_quo, pwm_quo;
   logic [11:0]   freq_sat;
   logic [7:0]    pwm_raw, pwm_adj;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // on*255 as (on<<8) - on
   assign total        = {1'b0, q_on} + {1'b0, q_off};
   assign pwm_dividend = {q_on, 8'd0} - {8'd0, q_on};

   // total / 50 by reciprocal multiplication on the registered total
   assign freq_prod = {{(VW+1){1'b0}}, tot_ff} * {{VW{1'b0}}, FREQ_RECIP[VW:0]};
   assign freq_quo  = {{(DW-VW+5){1'b0}}, freq_prod[2*VW:FS]};

   lsbc_div #(.DW(DW), .VW(VW)) u_pwm_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (pwm_dividend),
      .divisor  (total),
      .busy     (pwm_busy),
      .quotient (pwm_quo)
   );

   assign freq_sat = (freq_quo[DW-1:12] != '0) ? lsbc_pkg::FREQ_MAX : freq_quo[11:0];
   assign pwm_raw  = pwm_quo[7:0];
   assign pwm_adj  = ((pwm_raw != 8'd0) && (pwm_raw < lsbc_pkg::PWM_MIN)) ?
                     lsbc_pkg::PWM_MIN : pwm_raw;

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      out_in       = out_ff;
      freq_in      = freq_ff;
      pwm_in       = pwm_ff;
      tot_in       = tot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pop          = 1'b0;
      div_start    = 1'b0;
      unique case (state_ff)
         lsbc_pkg::ST_IDLE: begin
            if (q_valid && q_ctrl.blink) begin
               pop       = 1'b1;
               div_start = 1'b1;
               cur_in    = q_ctrl;
               tot_in    = total;
               state_in  = lsbc_pkg::ST_DIV;
            end else if (q_valid && out_free) begin
               pop          = 1'b1;
               out_in       = q_ctrl;
               freq_in      = 12'd0;
               pwm_in       = 8'd0;
               rsp_valid_in = 1'b1;
            end
         end
         lsbc_pkg::ST_DIV: begin
            if (!pwm_busy && out_free) begin
               out_in       = cur_ff;
               freq_in      = freq_sat;
               pwm_in       = pwm_adj;
               rsp_valid_in = 1'b1;
               state_in     = lsbc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lsbc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lsbc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      out_ff  <= out_in;
      freq_ff <= freq_in;
      pwm_ff  <= pwm_in;
      tot_ff  <= tot_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = out_ff.status;
   assign rsp_target     = out_ff.target;
   assign rsp_brightness = out_ff.brightness;
   assign rsp_blink      = out_ff.blink;
   assign rsp_group_freq = freq_ff;
   assign rsp_group_pwm  = pwm_ff;

   a_noblink_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !out_ff.blink) |-> (freq_ff == 12'd0 && pwm_ff == 8'd0))
      else $error("group fields nonzero without blink");

   a_blink_white: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && out_ff.blink) |->
      (out_ff.target == lsbc_pkg::TGT_WHITE && out_ff.status == lsbc_pkg::STATUS_OK))
      else $error("blink on a target other than the white led");

   a_pwm_floor: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && out_ff.blink) |-> (pwm_ff == 8'd0 || pwm_ff >= lsbc_pkg::PWM_MIN))
      else $error("pwm below floor");

   a_div_blink: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lsbc_pkg::ST_DIV) |-> cur_ff.blink)
      else $error("divider running for a non-blink request");

   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_start |=> (pwm_busy && state_ff == lsbc_pkg::ST_DIV))
      else $error("divider not running after start");

endmodule

FILE: rtl/led_light_state_blink_controller_top.sv
// ----------------------------------------------------------------------------
// led_light_state_blink_controller_top
// Light-state controller: luma brightness and white LED blink settings.
// ----------------------------------------------------------------------------
// Response path: queue entry, then response register; a blink request also
//   waits in ST_DIV for the bit-serial pwm divider.
// Throughput: one request per cycle into a 2-entry queue unless it is full;
//   the back end pops no request while the divider runs, and otherwise one
//   per cycle while the response register is free to take it.
// Reset: both white LED slots black, no flash, zero times; queue empty.
module led_light_state_blink_controller_top #(
   parameter int TIME_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_light_id,
   input  logic [23:0] req_color,
   input  logic [1:0]  req_flash_mode,
   input  logic [15:0] req_on_ms,
   input  logic [15:0] req_off_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_status,
   output logic [1:0]  rsp_target,
   output logic [7:0]  rsp_brightness,
   output logic        rsp_blink,
   output logic [11:0] rsp_group_freq,
   output logic [7:0]  rsp_group_pwm
);

   localparam int CTRL_W = $bits(lsbc_pkg::cmd_ctrl_type);
   localparam int ENT_W  = CTRL_W + 2 * TIME_WIDTH;

   logic                   q_full, push, pop, q_valid;
   lsbc_pkg::cmd_ctrl_type push_ctrl, q_ctrl;
   logic [TIME_WIDTH-1:0]  push_on, push_off, q_on, q_off;
   logic [ENT_W-1:0]       q_data;

   lsbc_front #(.TIME_WIDTH(TIME_WIDTH)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_light_id   (req_light_id),
      .req_color      (req_color),
      .req_flash_mode (req_flash_mode),
      .req_on_ms      (req_on_ms),
      .req_off_ms     (req_off_ms),
      .q_full         (q_full),
      .push           (push),
      .push_ctrl      (push_ctrl),
      .push_on        (push_on),
      .push_off       (push_off)
   );

   lsbc_queue #(.WIDTH(ENT_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_ctrl, push_on, push_off}),
      .full      (q_full),
      .pop       (pop),
      .q_valid   (q_valid),
      .q_data    (q_data)
   );

   assign q_ctrl = q_data[ENT_W-1 -: CTRL_W];
   assign q_on   = q_data[2*TIME_WIDTH-1 -: TIME_WIDTH];
   assign q_off  = q_data[TIME_WIDTH-1:0];

   lsbc_back #(.TIME_WIDTH(TIME_WIDTH)) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_ctrl         (q_ctrl),
      .q_on           (q_on),
      .q_off          (q_off),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_target     (rsp_target),
      .rsp_brightness (rsp_brightness),
      .rsp_blink      (rsp_blink),
      .rsp_group_freq (rsp_group_freq),
      .rsp_group_pwm  (rsp_group_pwm)
   );

endmodule
